// ----- rtl/core/mi3_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse.
// Element format, input and result beat structs. No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int ELEM_W        = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
    logic signed [ELEM_W-1:0] given_det;
    logic                     use_given_det;
  } item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic signed [ELEM_W-1:0] det_used;
    logic                     singular;
  } result_t;

endpackage

// ----- rtl/core/mi3_div.sv -----
// Pipelined rounding divider lane: signed cofactor over signed determinant.
// One quotient bit per stage, round half away from zero, saturate. Uses mi3_pkg.
`timescale 1ns / 1ps

module mi3_div
  import mi3_pkg::*;
(
  input  logic                       clk,
  input  logic                       ce,
  input  logic signed [2*ELEM_W:0]   num,
  input  logic signed [ELEM_W-1:0]   den,
  input  logic                       zero,
  output logic signed [ELEM_W-1:0]   quo
);

  localparam int W = ELEM_W;
  localparam logic [W:0] LIM_NEG = (W+1)'(1) << (W-1);
  localparam logic [W:0] LIM_POS = LIM_NEG - (W+1)'(1);

  logic [W-1:0] rem   [W+1];
  logic [W-1:0] low   [W+1];
  logic [W-1:0] qbits [W+1];
  logic [W-1:0] dmag  [W+1];
  logic         qneg  [W+1];
  logic         ovf   [W+1];
  logic         zer   [W+1];

  logic [2*W:0]   num_abs;
  logic [W-1:0]   den_abs;

  // prepare magnitudes, signs and the overflow check
  always_comb begin
    num_abs = num[2*W] ? (2*W+1)'(-num) : num;
    den_abs = den[W-1] ? W'(-den) : den;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0]   <= num_abs[2*W-1:W];
      low[0]   <= num_abs[W-1:0];
      qbits[0] <= '0;
      dmag[0]  <= den_abs;
      qneg[0]  <= num[2*W] ^ den[W-1];
      ovf[0]   <= num_abs[2*W-1:W] >= den_abs;
      zer[0]   <= zero;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem[k-1], low[k-1][W-1]};
    assign ge    = trial >= {1'b0, dmag[k-1]};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k]   <= ge ? W'(trial - {1'b0, dmag[k-1]}) : trial[W-1:0];
        low[k]   <= {low[k-1][W-2:0], 1'b0};
        qbits[k] <= {qbits[k-1][W-2:0], ge};
        dmag[k]  <= dmag[k-1];
        qneg[k]  <= qneg[k-1];
        ovf[k]   <= ovf[k-1];
        zer[k]   <= zer[k-1];
      end
    end
  end

  // round, apply sign, saturate
  logic         rnd;
  logic [W:0]   qmag;
  logic [W:0]   lim;
  logic [W:0]   qsat;
  logic [W-1:0] res;
  always_comb begin
    rnd  = rem[W] >= (dmag[W] - rem[W]);
    qmag = {1'b0, qbits[W]} + (W+1)'(rnd);
    lim  = qneg[W] ? LIM_NEG : LIM_POS;
    qsat = (ovf[W] || qmag > lim) ? lim : qmag;
    res  = qneg[W] ? W'(-qsat) : qsat[W-1:0];
    if (zer[W]) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quo <= res;
    end
  end

endmodule

// ----- rtl/core/matrix3x3_inverse.sv -----
// 3x3 matrix inverse by the adjugate, signed fixed point.
// Top level: cofactor, determinant and rounding stages, nine mi3_div lanes,
// output skid register. Uses mi3_pkg and mi3_div.
//
// Usage:
//   src_* carries one matrix per beat (item_t), res_* one inverse (result_t).
//   Both channels are valid/ready; a beat moves when valid and ready are high.
//   The pipeline has six stages for cofactor products, cofactors,
//   determinant partial products, partial sums, the full determinant and its
//   rounding, then ELEM_W + 2 stages in each divider lane (setup, one quotient
//   bit per stage, rounding).
//   Throughput is one matrix per cycle while the skid register is empty; every stage advances together.
//   A zero determinant in use gives singular = 1 and all-zero outputs.
//   When res_ready is low the output beat moves into a skid register while the
//   pipeline advances; src_ready then drops until the skid register drains.
//   src_ready is driven from a register only.
//   Reset (rst, synchronous) empties the pipeline and the skid register.
`timescale 1ns / 1ps

module matrix3x3_inverse
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  output logic    src_ready,
  input  item_t   src_data,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  localparam int W   = ELEM_W;
  localparam int CW  = 2*W + 1;
  localparam int PW  = 2*W + 1;
  localparam int SW  = 2*W + 3;
  localparam int DW  = 3*W + 3;
  localparam int DL  = W + 2;
  localparam int L   = 6 + DL;
  localparam logic [DW-1:0] HALF    = DW'(1) << (2*FRAC_BITS - 1);
  localparam logic [DW-1:0] LIM_NEG = DW'(1) << (W-1);
  localparam logic [DW-1:0] LIM_POS = LIM_NEG - DW'(1);

  logic ce;
  logic vpipe [L];

  logic signed [W-1:0] me [9];
  assign me[0] = src_data.m00;
  assign me[1] = src_data.m01;
  assign me[2] = src_data.m02;
  assign me[3] = src_data.m10;
  assign me[4] = src_data.m11;
  assign me[5] = src_data.m12;
  assign me[6] = src_data.m20;
  assign me[7] = src_data.m21;
  assign me[8] = src_data.m22;

  logic signed [2*W-1:0] pa [9];
  logic signed [2*W-1:0] pb [9];
  logic signed [CW-1:0]  cof2 [9];
  logic signed [CW-1:0]  cof3 [9];
  logic signed [CW-1:0]  cof4 [9];
  logic signed [CW-1:0]  cof5 [9];
  logic signed [CW-1:0]  cof6 [9];
  logic signed [W-1:0]   mc1 [3];
  logic signed [W-1:0]   mc2 [3];
  logic signed [PW-1:0]  plo [3];
  logic signed [PW-1:0]  phi [3];
  logic signed [SW-1:0]  slo;
  logic signed [SW-1:0]  shi;
  logic signed [DW-1:0]  det;
  logic signed [W-1:0]   gd [1:5];
  logic                  ug [1:5];
  logic signed [W-1:0]   dused;
  logic                  sing;
  logic signed [W-1:0]   dd [DL];
  logic                  sd [DL];

  // stage 1: cofactor products
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int P = (c + 1) % 3;
      localparam int Q = (c + 2) % 3;
      localparam int S = (i + 1) % 3;
      localparam int T = (i + 2) % 3;
      always_ff @(posedge clk) begin
        if (ce) begin
          pa[i*3+c] <= me[P*3+S] * me[Q*3+T];
          pb[i*3+c] <= me[P*3+T] * me[Q*3+S];
        end
      end
    end
  end

  // stages 1..6: cofactors and side data for the determinant
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        mc1[k] <= me[k*3];
        mc2[k] <= mc1[k];
      end
      for (int k = 0; k < 9; k++) begin
        cof2[k] <= CW'(pa[k]) - CW'(pb[k]);
        cof3[k] <= cof2[k];
        cof4[k] <= cof3[k];
        cof5[k] <= cof4[k];
        cof6[k] <= cof5[k];
      end
      gd[1] <= src_data.given_det;
      ug[1] <= src_data.use_given_det;
      for (int k = 2; k <= 5; k++) begin
        gd[k] <= gd[k-1];
        ug[k] <= ug[k-1];
      end
    end
  end

  // stage 3: split each first-row cofactor into halves for W-bit multiplies
  for (genvar i = 0; i < 3; i++) begin : g_dp
    logic signed [W:0] lo_part;
    logic signed [W:0] hi_part;
    assign lo_part = {1'b0, cof2[i][W-1:0]};
    assign hi_part = cof2[i][2*W:W];
    always_ff @(posedge clk) begin
      if (ce) begin
        plo[i] <= mc2[i] * lo_part;
        phi[i] <= mc2[i] * hi_part;
      end
    end
  end

  // stages 4 and 5: sum partials, then recombine
  always_ff @(posedge clk) begin
    if (ce) begin
      slo <= SW'(plo[0]) + SW'(plo[1]) + SW'(plo[2]);
      shi <= SW'(phi[0]) + SW'(phi[1]) + SW'(phi[2]);
      det <= (DW'(shi) <<< W) + DW'(slo);
    end
  end

  // stage 6: round the determinant, saturate, pick the one in use
  logic [DW-1:0] dmag;
  logic [DW-1:0] drnd;
  logic [DW-1:0] dcap;
  logic [W-1:0]  dcomp;
  logic [W-1:0]  dsel;
  always_comb begin
    dmag  = det[DW-1] ? DW'(-det) : det;
    drnd  = (dmag + HALF) >> (2*FRAC_BITS);
    if (det[DW-1]) begin
      dcap  = (drnd > LIM_NEG) ? LIM_NEG : drnd;
      dcomp = W'(-dcap);
    end else begin
      dcap  = (drnd > LIM_POS) ? LIM_POS : drnd;
      dcomp = dcap[W-1:0];
    end
    dsel = ug[5] ? gd[5] : dcomp;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dused <= dsel;
      sing  <= (dsel == '0);
    end
  end

  // divider lanes
  logic signed [W-1:0] rq [9];
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div u_div (
      .clk  (clk),
      .ce   (ce),
      .num  (cof6[k]),
      .den  (dused),
      .zero (sing),
      .quo  (rq[k])
    );
  end

  // carry the determinant and the singular flag alongside the lanes
  always_ff @(posedge clk) begin
    if (ce) begin
      dd[0] <= dused;
      sd[0] <= sing;
      for (int k = 1; k < DL; k++) begin
        dd[k] <= dd[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) begin
        vpipe[k] <= 1'b0;
      end
    end else if (ce) begin
      vpipe[0] <= src_valid;
      for (int k = 1; k < L; k++) begin
        vpipe[k] <= vpipe[k-1];
      end
    end
  end

  result_t pipe_res;
  always_comb begin
    pipe_res.r00      = rq[0];
    pipe_res.r01      = rq[1];
    pipe_res.r02      = rq[2];
    pipe_res.r10      = rq[3];
    pipe_res.r11      = rq[4];
    pipe_res.r12      = rq[5];
    pipe_res.r20      = rq[6];
    pipe_res.r21      = rq[7];
    pipe_res.r22      = rq[8];
    pipe_res.det_used = sd[DL-1] ? '0 : dd[DL-1];
    pipe_res.singular = sd[DL-1];
  end

  // skid register: hold a stalled output beat, let the pipeline advance
  logic    skid_valid;
  result_t skid_data;
  assign ce        = !skid_valid;
  assign src_ready = ce;
  assign res_valid = skid_valid || vpipe[L-1];
  assign res_data  = skid_valid ? skid_data : pipe_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (vpipe[L-1] && !res_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_data <= pipe_res;
    end
  end

`ifndef SYNTHESIS
  a_sing_zero_det: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.singular |-> res_data.det_used == '0)
    else $error("singular beat with nonzero determinant");

  a_sing_zero_inv: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.singular |->
      res_data.r00 == '0 && res_data.r11 == '0 && res_data.r22 == '0)
    else $error("singular beat with nonzero inverse");

  a_regular_det: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.singular |-> res_data.det_used != '0)
    else $error("regular beat with zero determinant");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(vpipe[L-1] && !res_ready))
    else $error("skid register filled without a stall");
`endif

endmodule

// ----- verif/mi3_checker.sv -----
// Scoreboard for the 3x3 matrix inverse: predicts each inverse from the input beat
// and compares it with the result beats. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_checker
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  input  logic    src_ready,
  input  item_t   src_data,
  input  logic    res_valid,
  input  logic    res_ready,
  input  result_t res_data,
  output int      fail_count,
  output int      pending,
  output int      n_results,
  output int      n_singular
);

  // wide enough for any cofactor product or determinant, exact
  typedef logic signed [191:0] wide_t;

  result_t inverse_q[$];

  // clamp a wide value to the element range
  function automatic logic signed [ELEM_W-1:0] clamp_elem(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (ELEM_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (ELEM_W - 1));
    if (v > hi) return {1'b0, {(ELEM_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(ELEM_W-1){1'b0}}};
    return v[ELEM_W-1:0];
  endfunction

  // quotient rounded half away from zero
  function automatic wide_t quot_round(wide_t num, logic signed [ELEM_W-1:0] d);
    wide_t nm;
    wide_t dm;
    wide_t q;
    wide_t rem;
    nm = (num < 0) ? -num : num;
    dm = d;
    if (dm < 0) dm = -dm;
    q = nm / dm;
    rem = nm - q * dm;
    if (rem >= dm - rem) q = q + 1;
    return ((num < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic result_t invert(item_t it);
    wide_t e[3][3];
    wide_t cof[3][3];
    wide_t det;
    wide_t mag;
    logic signed [ELEM_W-1:0] dused;
    logic signed [ELEM_W-1:0] inv[3][3];
    result_t r;
    int p, q, s, t;
    e[0][0] = it.m00; e[0][1] = it.m01; e[0][2] = it.m02;
    e[1][0] = it.m10; e[1][1] = it.m11; e[1][2] = it.m12;
    e[2][0] = it.m20; e[2][1] = it.m21; e[2][2] = it.m22;
    // transposed cofactors
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        p = (c + 1) % 3; q = (c + 2) % 3;
        s = (i + 1) % 3; t = (i + 2) % 3;
        cof[i][c] = e[p][s] * e[q][t] - e[p][t] * e[q][s];
      end
    end
    if (it.use_given_det) begin
      dused = it.given_det;
    end else begin
      det = 0;
      for (int i = 0; i < 3; i++) det = det + e[i][0] * cof[0][i];
      mag = (det < 0) ? -det : det;
      mag = (mag + (wide_t'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      dused = clamp_elem((det < 0) ? -mag : mag);
    end
    r = '0;
    if (dused == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      for (int c = 0; c < 3; c++)
        inv[i][c] = clamp_elem(quot_round(cof[i][c], dused));
    r.r00 = inv[0][0]; r.r01 = inv[0][1]; r.r02 = inv[0][2];
    r.r10 = inv[1][0]; r.r11 = inv[1][1]; r.r12 = inv[1][2];
    r.r20 = inv[2][0]; r.r21 = inv[2][1]; r.r22 = inv[2][2];
    r.det_used = dused;
    r.singular = 1'b0;
    return r;
  endfunction

  task automatic check_field(string name, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  assign pending = inverse_q.size();

  // clear the counters in reset, queue each accepted matrix, compare each result beat
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fail_count = 0;
      n_results  = 0;
      n_singular = 0;
    end else begin
      if (src_valid && src_ready) inverse_q.push_back(invert(src_data));
      if (res_valid && res_ready) begin
        n_results++;
        if (inverse_q.size() == 0) begin
          $error("result beat with no matrix outstanding");
          fail_count++;
        end else begin
          want = inverse_q.pop_front();
          if (want.singular) n_singular++;
          check_field("r00", want.r00, res_data.r00);
          check_field("r01", want.r01, res_data.r01);
          check_field("r02", want.r02, res_data.r02);
          check_field("r10", want.r10, res_data.r10);
          check_field("r11", want.r11, res_data.r11);
          check_field("r12", want.r12, res_data.r12);
          check_field("r20", want.r20, res_data.r20);
          check_field("r21", want.r21, res_data.r21);
          check_field("r22", want.r22, res_data.r22);
          check_field("det_used", want.det_used, res_data.det_used);
          check_field("singular", ELEM_W'(want.singular), ELEM_W'(res_data.singular));
        end
      end
    end
  end

endmodule

// ----- verif/tb_matrix3x3_inverse.sv -----
// Testbench top for matrix3x3_inverse: clock, reset, matrix stimulus and result
// back-pressure, verdict. Uses mi3_pkg and the mi3_checker scoreboard.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse;
  import mi3_pkg::*;

  localparam int LATENCY = ELEM_W + 8;
  localparam logic signed [ELEM_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [ELEM_W-1:0] EMAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] EMIN = 32'sh8000_0000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    src_valid = 1'b0;
  logic    src_ready;
  item_t   src_data = '0;
  logic    res_valid;
  logic    res_ready = 1'b0;
  result_t res_data;

  int fail_count, pending, n_results, n_singular;
  int n_sent = 0;
  bit quiet = 1'b0;   // no idling on either side
  int hold_cycles = 0;

  always #5 clk = ~clk;

  matrix3x3_inverse u_dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_data(src_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
  );

  mi3_checker u_chk (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_data(src_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .fail_count(fail_count), .pending(pending),
    .n_results(n_results), .n_singular(n_singular)
  );

  // present one matrix beat and hold it until accepted
  task automatic send_matrix(item_t it);
    while (!quiet && $urandom_range(99) < 14) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= it;
    do @(posedge clk); while (!src_ready);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic item_t diag(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                                 logic signed [ELEM_W-1:0] c);
    item_t it;
    it = '0;
    it.m00 = a; it.m11 = b; it.m22 = c;
    return it;
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem(int scale);
    case (scale)
      0: return $signed($urandom());                                // full range
      1: return $signed(32'($urandom_range(0, 2 * 4 * 65536)) - 32'(4 * 65536));
      2: return $signed(32'($urandom_range(0, 64)) - 32'd32);       // tiny
      default: return $signed(32'($urandom_range(0, 2 * 256 * 65536)) - 32'(256 * 65536));
    endcase
  endfunction

  function automatic item_t rand_matrix();
    item_t it;
    int scale;
    scale = $urandom_range(0, 9);
    scale = (scale < 2) ? 0 : (scale < 7) ? 1 : (scale < 8) ? 2 : 3;
    it.m00 = rand_elem(scale); it.m01 = rand_elem(scale); it.m02 = rand_elem(scale);
    it.m10 = rand_elem(scale); it.m11 = rand_elem(scale); it.m12 = rand_elem(scale);
    it.m20 = rand_elem(scale); it.m21 = rand_elem(scale); it.m22 = rand_elem(scale);
    // copy a row now and then to hit singular matrices
    if ($urandom_range(0, 19) == 0) begin
      it.m20 = it.m00; it.m21 = it.m01; it.m22 = it.m02;
    end
    it.given_det = ($urandom_range(0, 3) == 0) ? rand_elem($urandom_range(0, 3))
                                               : $signed($urandom());
    if ($urandom_range(0, 15) == 0) it.given_det = '0;
    it.use_given_det = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // result side: random back-pressure plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_sent >= 80) begin
        held = 1'b1;
        hold_cycles = 200;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= quiet || ($urandom_range(99) >= 14);
      end
    end
  end

  // stimulus
  initial begin
    item_t it;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity, scaled, singular, extremes, given determinant cases
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix(diag(2 * ONE, -ONE, ONE / 2));
    send_matrix('0);
    send_matrix(diag(EMAX, EMAX, EMAX));
    send_matrix(diag(EMIN, EMIN, EMIN));
    send_matrix(diag(EMIN, EMAX, EMIN));
    send_matrix(diag(32'sd1, 32'sd1, 32'sd1));         // determinant rounds to zero
    send_matrix(diag(ONE, 32'sd1, ONE));              // tiny determinant, overflow
    it = diag(ONE, ONE, ONE);
    it.m01 = EMAX; it.m12 = EMIN; it.m20 = EMAX;
    send_matrix(it);
    it = '1;
    send_matrix(it);
    it = diag(ONE, ONE, ONE);
    it.use_given_det = 1'b1;
    it.given_det = '0;     send_matrix(it);
    it.given_det = 32'sd1; send_matrix(it);
    it.given_det = -32'sd1; send_matrix(it);
    it.given_det = EMAX;   send_matrix(it);
    it.given_det = EMIN;   send_matrix(it);
    it = '0;
    it.m00 = EMIN; it.m01 = EMIN; it.m02 = EMIN;
    it.m10 = EMAX; it.m11 = EMIN; it.m12 = EMAX;
    it.m20 = EMIN; it.m21 = EMAX; it.m22 = EMAX;
    send_matrix(it);
    it = '0;
    it.m01 = ONE; it.m12 = ONE; it.m20 = ONE;         // permutation, zero diagonal
    send_matrix(it);
    it.m01 = -ONE;
    send_matrix(it);

    // random
    for (int k = 0; k < 500; k++) begin
      quiet = (k >= 200 && k < 300);
      send_matrix(rand_matrix());
    end
    quiet = 1'b0;
    src_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d matrices, checked %0d inverses (%0d singular),",
             n_sent, n_results, n_singular);
    $display("with random idling on both sides and one long result stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mi3_pkg.sv
rtl/core/mi3_div.sv
rtl/core/matrix3x3_inverse.sv
verif/mi3_checker.sv
verif/tb_matrix3x3_inverse.sv
